>>> rtl/ppt_pkg.sv
// Package for the projective point transform: widths, codes and item types.
// Used by ppt_front, ppt_cell and projective_point_transform.
`default_nettype none
package ppt_pkg;

  localparam int unsigned COORD_BITS = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned COEF_BITS  = 32;
  localparam int unsigned NUM_COEFS  = 9;
  localparam int unsigned PROD_BITS  = COORD_BITS + COEF_BITS;
  localparam int unsigned SUM_BITS   = COORD_BITS + COEF_BITS + 2;
  localparam int unsigned NUM_BITS   = SUM_BITS + FRAC_BITS;
  localparam int unsigned OVF_BITS   = SUM_BITS + COORD_BITS - FRAC_BITS;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ROW0_A_B      = 3'd0,
    CFG_ROW0_C_ROW1_A = 3'd1,
    CFG_ROW1_B_C      = 3'd2,
    CFG_ROW2_A_B      = 3'd3,
    CFG_ROW2_C        = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_W_ZERO = 2'd1,
    STATUS_SAT    = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    status_e                      status;
    logic                         last_out;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic w_zero;
  } ctl_t;

  typedef struct packed {
    logic                  neg;
    logic                  num_neg;
    logic                  num_nz;
    logic                  ovf;
    logic [SUM_BITS-1:0]   rem;
    logic [COORD_BITS-1:0] num;
    logic [COORD_BITS-1:0] quo;
  } lane_t;

endpackage
`default_nettype wire

>>> rtl/ppt_front.sv
// Front end: input register, coefficient products, sums and divider setup.
// Depends on ppt_pkg.
`default_nettype none
module ppt_front
  import ppt_pkg::*;
(
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 adv_i,
  input  wire logic                                 in_valid_i,
  input  wire in_item_t                             in_item_i,
  input  wire logic [NUM_COEFS-1:0][COEF_BITS-1:0]  coef_i,
  output ctl_t                                      ctl_o,
  output logic [SUM_BITS-1:0]                       den_o,
  output lane_t                                     lane_u_o,
  output lane_t                                     lane_v_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic l1_q, l2_q, l3_q, l4_q;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic signed [PROD_BITS-1:0] pux_q, puy_q, pvx_q, pvy_q, pwx_q, pwy_q;
  logic signed [PROD_BITS-1:0] pux_d, puy_d, pvx_d, pvy_d, pwx_d, pwy_d;
  logic signed [SUM_BITS-1:0] u_q, v_q, w_q, u_d, v_d, w_d;
  logic [SUM_BITS-1:0] mu, mv, mw;
  logic [NUM_BITS-1:0] nu, nv;
  logic zero_q;
  logic [SUM_BITS-1:0] den_q;
  lane_t lu_d, lv_d, lu_q, lv_q;

  function automatic logic signed [SUM_BITS-1:0] const_term(input logic [COEF_BITS-1:0] c);
    logic signed [COEF_BITS+FRAC_BITS-1:0] t;
    t = $signed({c, {FRAC_BITS{1'b0}}});
    return SUM_BITS'(t);
  endfunction

  always_comb begin
    pux_d = x_q * $signed(coef_i[0]);
    puy_d = y_q * $signed(coef_i[1]);
    pvx_d = x_q * $signed(coef_i[3]);
    pvy_d = y_q * $signed(coef_i[4]);
    pwx_d = x_q * $signed(coef_i[6]);
    pwy_d = y_q * $signed(coef_i[7]);
    u_d = SUM_BITS'(pux_q) + SUM_BITS'(puy_q) + const_term(coef_i[2]);
    v_d = SUM_BITS'(pvx_q) + SUM_BITS'(pvy_q) + const_term(coef_i[5]);
    w_d = SUM_BITS'(pwx_q) + SUM_BITS'(pwy_q) + const_term(coef_i[8]);
    mu = u_q[SUM_BITS-1] ? SUM_BITS'(-u_q) : SUM_BITS'(u_q);
    mv = v_q[SUM_BITS-1] ? SUM_BITS'(-v_q) : SUM_BITS'(v_q);
    mw = w_q[SUM_BITS-1] ? SUM_BITS'(-w_q) : SUM_BITS'(w_q);
    nu = {mu, {FRAC_BITS{1'b0}}};
    nv = {mv, {FRAC_BITS{1'b0}}};
    lu_d.neg     = u_q[SUM_BITS-1] ^ w_q[SUM_BITS-1];
    lu_d.num_neg = u_q[SUM_BITS-1];
    lu_d.num_nz  = |u_q;
    lu_d.ovf     = OVF_BITS'(mu) >= (OVF_BITS'(mw) << (COORD_BITS - FRAC_BITS));
    lu_d.rem     = SUM_BITS'(nu >> COORD_BITS);
    lu_d.num     = nu[COORD_BITS-1:0];
    lu_d.quo     = '0;
    lv_d.neg     = v_q[SUM_BITS-1] ^ w_q[SUM_BITS-1];
    lv_d.num_neg = v_q[SUM_BITS-1];
    lv_d.num_nz  = |v_q;
    lv_d.ovf     = OVF_BITS'(mv) >= (OVF_BITS'(mw) << (COORD_BITS - FRAC_BITS));
    lv_d.rem     = SUM_BITS'(nv >> COORD_BITS);
    lv_d.num     = nv[COORD_BITS-1:0];
    lv_d.quo     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q    <= in_item_i.point_x;
      y_q    <= in_item_i.point_y;
      l1_q   <= in_item_i.last_in;
      pux_q  <= pux_d;
      puy_q  <= puy_d;
      pvx_q  <= pvx_d;
      pvy_q  <= pvy_d;
      pwx_q  <= pwx_d;
      pwy_q  <= pwy_d;
      l2_q   <= l1_q;
      u_q    <= u_d;
      v_q    <= v_d;
      w_q    <= w_d;
      l3_q   <= l2_q;
      lu_q   <= lu_d;
      lv_q   <= lv_d;
      den_q  <= mw;
      zero_q <= ~|w_q;
      l4_q   <= l3_q;
    end
  end

  assign ctl_o.valid  = v4_q;
  assign ctl_o.last   = l4_q;
  assign ctl_o.w_zero = zero_q;
  assign den_o        = den_q;
  assign lane_u_o     = lu_q;
  assign lane_v_o     = lv_q;

endmodule
`default_nettype wire

>>> rtl/ppt_cell.sv
// Divider cell: one restoring quotient bit for the u and v lanes per cycle while adv_i is high.
// Depends on ppt_pkg.
`default_nettype none
module ppt_cell
  import ppt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire ctl_t                 ctl_i,
  input  wire logic [SUM_BITS-1:0]  den_i,
  input  wire lane_t                lane_u_i,
  input  wire lane_t                lane_v_i,
  output ctl_t                      ctl_o,
  output logic [SUM_BITS-1:0]       den_o,
  output lane_t                     lane_u_o,
  output lane_t                     lane_v_o
);

  logic valid_q, last_q, w_zero_q;
  logic [SUM_BITS-1:0] den_q;
  lane_t lu_q, lv_q, lu_d, lv_d;

  function automatic lane_t step(input lane_t l, input logic [SUM_BITS-1:0] d);
    lane_t r;
    logic [SUM_BITS:0] rs;
    logic take;
    r    = l;
    rs   = {l.rem, l.num[COORD_BITS-1]};
    take = rs >= {1'b0, d};
    r.rem = take ? SUM_BITS'(rs - {1'b0, d}) : SUM_BITS'(rs);
    r.num = l.num << 1;
    r.quo = {l.quo[COORD_BITS-2:0], take};
    return r;
  endfunction

  always_comb begin
    lu_d = step(lane_u_i, den_i);
    lv_d = step(lane_v_i, den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      last_q   <= ctl_i.last;
      w_zero_q <= ctl_i.w_zero;
      den_q    <= den_i;
      lu_q     <= lu_d;
      lv_q     <= lv_d;
    end
  end

  assign ctl_o.valid  = valid_q;
  assign ctl_o.last   = last_q;
  assign ctl_o.w_zero = w_zero_q;
  assign den_o        = den_q;
  assign lane_u_o     = lu_q;
  assign lane_v_o     = lv_q;

endmodule
`default_nettype wire

>>> rtl/projective_point_transform.sv
// Top level of the projective point transform: coefficient registers,
// front end, divider cell chain and output register. Depends on ppt_pkg,
// ppt_front and ppt_cell.
//
// Usage: an input item (x, y, last) enters on in_valid_i while in_stall_o
// is low; one result item (u/w, v/w, status, last) leaves on out_valid_o
// while out_stall_i is low. Results keep input order.
// Coefficients are written on the cfg channel (index, data), which is
// always ready; write them only while no item is in flight.
// The result passes, after the edge that accepts the item, through the input
// register, products, sums, divider setup, one cell per quotient bit and the
// output register.
// Throughput is one item per cycle while the pipeline is not held by a stall;
// the quotient chain of COORD_BITS cells sets the latency.
// Reset clears all valid flags and loads the identity matrix.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_stall_o rises in the same cycle.
`default_nettype none
module projective_point_transform
  import ppt_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire in_item_t                  in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output out_item_t                      out_item_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  localparam logic [COORD_BITS-1:0] MAX_VAL = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MIN_VAL = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0]  ONE_VAL = COEF_BITS'(1) << FRAC_BITS;
  localparam logic [NUM_COEFS-1:0][COEF_BITS-1:0] COEF_RESET = {
    ONE_VAL, {(3*COEF_BITS){1'b0}}, ONE_VAL, {(3*COEF_BITS){1'b0}}, ONE_VAL
  };

  logic [NUM_COEFS-1:0][COEF_BITS-1:0] coef_q;
  logic adv;
  ctl_t ctl [COORD_BITS+1];
  logic [SUM_BITS-1:0] den [COORD_BITS+1];
  lane_t lane_u [COORD_BITS+1];
  lane_t lane_v [COORD_BITS+1];
  logic out_valid_q;
  out_item_t out_q, out_d;
  logic sat_x, sat_y;
  logic [COORD_BITS-1:0] val_x, val_y;

  assign cfg_ready_o = 1'b1;
  assign adv         = ~(out_valid_q & out_stall_i);
  assign in_stall_o  = ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= COEF_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_ROW0_A_B: begin
          coef_q[0] <= cfg_data_i[31:0];
          coef_q[1] <= cfg_data_i[63:32];
        end
        CFG_ROW0_C_ROW1_A: begin
          coef_q[2] <= cfg_data_i[31:0];
          coef_q[3] <= cfg_data_i[63:32];
        end
        CFG_ROW1_B_C: begin
          coef_q[4] <= cfg_data_i[31:0];
          coef_q[5] <= cfg_data_i[63:32];
        end
        CFG_ROW2_A_B: begin
          coef_q[6] <= cfg_data_i[31:0];
          coef_q[7] <= cfg_data_i[63:32];
        end
        CFG_ROW2_C: begin
          coef_q[8] <= cfg_data_i[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  ppt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .coef_i     (coef_q),
    .ctl_o      (ctl[0]),
    .den_o      (den[0]),
    .lane_u_o   (lane_u[0]),
    .lane_v_o   (lane_v[0])
  );

  for (genvar i = 0; i < COORD_BITS; i++) begin : g_cell
    ppt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .ctl_i    (ctl[i]),
      .den_i    (den[i]),
      .lane_u_i (lane_u[i]),
      .lane_v_i (lane_v[i]),
      .ctl_o    (ctl[i+1]),
      .den_o    (den[i+1]),
      .lane_u_o (lane_u[i+1]),
      .lane_v_o (lane_v[i+1])
    );
  end

  function automatic logic [COORD_BITS:0] finish(input lane_t l, input logic zero);
    logic [COORD_BITS-1:0] v;
    logic s;
    s = 1'b0;
    if (zero) begin
      v = !l.num_nz ? '0 : (l.num_neg ? MIN_VAL : MAX_VAL);
    end else if (l.neg) begin
      if (l.ovf || l.quo > MIN_VAL) begin
        v = MIN_VAL;
        s = 1'b1;
      end else begin
        v = COORD_BITS'(-l.quo);
      end
    end else begin
      if (l.ovf || l.quo[COORD_BITS-1]) begin
        v = MAX_VAL;
        s = 1'b1;
      end else begin
        v = l.quo;
      end
    end
    return {s, v};
  endfunction

  always_comb begin
    {sat_x, val_x} = finish(lane_u[COORD_BITS], ctl[COORD_BITS].w_zero);
    {sat_y, val_y} = finish(lane_v[COORD_BITS], ctl[COORD_BITS].w_zero);
    out_d.out_x    = $signed(val_x);
    out_d.out_y    = $signed(val_y);
    out_d.last_out = ctl[COORD_BITS].last;
    if (ctl[COORD_BITS].w_zero) begin
      out_d.status = STATUS_W_ZERO;
    end else if (sat_x || sat_y) begin
      out_d.status = STATUS_SAT;
    end else begin
      out_d.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= ctl[COORD_BITS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire
